>>> sv/page_boundary_access_split_assert.svh
// ----------------------------------------------------------------------------
// Page boundary access split - assertion macros
// Shared property forms for the port-level checks of the block.
// ----------------------------------------------------------------------------
`ifndef PAGE_BOUNDARY_ACCESS_SPLIT_ASSERT_SVH
`define PAGE_BOUNDARY_ACCESS_SPLIT_ASSERT_SVH

// same-cycle implication, held off during reset
`define PBAS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, held off during reset
`define PBAS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/pbas_pkg.sv
// ----------------------------------------------------------------------------
// Page boundary access split - package
// Widths, reset values, sequencer states and the divider interface types.
// ----------------------------------------------------------------------------
package pbas_pkg;

   localparam int ADDR_W      = 32;
   localparam int PS_W        = 13;
   localparam int LEN_W       = 8;
   localparam int PAGE_W      = 29;
   localparam int OFF_W       = 12;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 56;
   localparam int RSP_PAD_W   = RSP_TDATA_W - PAGE_W - OFF_W - LEN_W;

   localparam int unsigned MAX_PAGE_SIZE_DEF = 4096;

   localparam logic [PS_W-1:0] PAGE_SIZE_RESET = 13'd32;
   localparam logic [PS_W-1:0] PS_MIN          = 13'd8;

   localparam int DIV_STEPS = ADDR_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } pbas_state_type;

   typedef struct packed {
      logic              start;
      logic [ADDR_W-1:0] dividend;
      logic [PS_W-1:0]   divisor;
   } pbas_div_ctrl_type;

   typedef struct packed {
      logic              done;
      logic [ADDR_W-1:0] quotient;
      logic [PS_W-1:0]   remainder;
   } pbas_div_stat_type;

endpackage

>>> sv/page_boundary_access_split.sv
// ----------------------------------------------------------------------------
// Page boundary access split - top level
// Splits one access into one item per page touched.
//
//   port group  dir  contents
//   req_*       in   tdata: address[31:0], access_length[39:32]; tuser: wide
//   rsp_*       out  tdata: page_number, page_offset, segment_length; tlast
//   csr_*       in   page_size write, 13 bits
//
// An item is taken, the divider runs its 32 quotient-bit steps and the quotient
// is picked up; then the segments are registered in turn, each held while
// rsp_tready is low. req_tready is low until the last segment is in the result
// register. The next item is taken while that last segment still waits.
// Synchronous reset sets page_size to 32 and empties the result register.
// ----------------------------------------------------------------------------
module page_boundary_access_split #(
   parameter int unsigned MAX_PAGE_SIZE = pbas_pkg::MAX_PAGE_SIZE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [31:0] address, [39:32] access_length
   input  logic [pbas_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [0] register_is_wide
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [28:0] page_number, [40:29] page_offset, [48:41] segment_length, rest 0
   output logic [pbas_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_wr_en,
   input  logic [pbas_pkg::PS_W-1:0]         csr_wr_data
);
   import pbas_pkg::*;

   pbas_div_ctrl_type div_ctrl;
   pbas_div_stat_type div_stat;

   pbas_seq #(
      .MAX_PAGE_SIZE (MAX_PAGE_SIZE)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .div_ctrl    (div_ctrl),
      .div_stat    (div_stat)
   );

   pbas_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_ctrl (div_ctrl),
      .div_stat (div_stat)
   );

endmodule

>>> sv/pbas_div.sv
// ----------------------------------------------------------------------------
// Page boundary access split - serial divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pbas_div (
   input  logic                       clock,
   input  logic                       reset,
   input  pbas_pkg::pbas_div_ctrl_type div_ctrl,
   output pbas_pkg::pbas_div_stat_type div_stat
);
   import pbas_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ADDR_W-1:0]    quo_ff, quo_in;
   logic [PS_W-1:0]      rem_ff, rem_in;
   logic [PS_W-1:0]      dvs_ff, dvs_in;

   logic [PS_W:0]        trial;
   logic [PS_W+1:0]      diff;
   logic                 fits;

   // partial remainder stays below the divisor, so PS_W bits hold it
   assign trial = {rem_ff, quo_ff[ADDR_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, dvs_ff};
   assign fits  = ~diff[PS_W+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_ctrl.dividend;
         rem_in  = '0;
         dvs_in  = div_ctrl.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[ADDR_W-2:0], fits};
         rem_in = fits ? diff[PS_W-1:0] : trial[PS_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_stat.done      = done_ff;
   assign div_stat.quotient  = quo_ff;
   assign div_stat.remainder = rem_ff;

endmodule

>>> sv/pbas_seq.sv
// ----------------------------------------------------------------------------
// Page boundary access split - sequencer
// Holds the page size register, starts the divider per item and walks the
// access one page per cycle into the result register, holding while it is full.
// ----------------------------------------------------------------------------
module pbas_seq #(
   parameter int unsigned MAX_PAGE_SIZE = pbas_pkg::MAX_PAGE_SIZE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pbas_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pbas_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_wr_en,
   input  logic [pbas_pkg::PS_W-1:0]         csr_wr_data,
   output pbas_pkg::pbas_div_ctrl_type       div_ctrl,
   input  pbas_pkg::pbas_div_stat_type       div_stat
);
   import pbas_pkg::*;

   pbas_state_type           state_ff, state_in;
   logic [PS_W-1:0]          page_size_ff, page_size_in;
   logic [PS_W-1:0]          ps_ff, ps_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic [PAGE_W-1:0]        page_ff, page_in;
   logic [PS_W-1:0]          off_ff, off_in;
   logic [LEN_W-1:0]         remain_ff, remain_in;
   logic                     first_ff, first_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic [PS_W-1:0]          ps_clamped;
   logic [PS_W-1:0]          avail;
   logic [LEN_W-1:0]         seg_len;
   logic [LEN_W-1:0]         rem_next;
   logic                     seg_last;
   logic                     slot_free;
   logic                     req_take;
   logic [ADDR_W-1:0]        addr_sel;

   always_comb begin
      if (page_size_ff < PS_MIN)
         ps_clamped = PS_MIN;
      else if (32'(page_size_ff) > MAX_PAGE_SIZE)
         ps_clamped = PS_W'(MAX_PAGE_SIZE);
      else
         ps_clamped = page_size_ff;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid & req_tready;
   assign addr_sel   = req_tuser ? req_tdata[ADDR_W-1:0]
                                 : {{(ADDR_W-8){1'b0}}, req_tdata[7:0]};
   assign slot_free  = ~rsp_valid_ff | rsp_tready;

   // segment in hand: first one runs from the offset, later ones whole pages but the last
   assign avail = ps_ff - off_ff;
   always_comb begin
      seg_len  = '0;
      seg_last = 1'b1;
      rem_next = remain_ff;
      if (first_ff) begin
         if (avail >= {{(PS_W-LEN_W){1'b0}}, len_ff}) begin
            seg_len = len_ff;
         end else begin
            seg_len  = avail[LEN_W-1:0];
            seg_last = 1'b0;
            rem_next = len_ff - avail[LEN_W-1:0];
         end
      end else begin
         if ({{(PS_W-LEN_W){1'b0}}, remain_ff} > ps_ff) begin
            seg_len  = ps_ff[LEN_W-1:0];
            seg_last = 1'b0;
            rem_next = remain_ff - ps_ff[LEN_W-1:0];
         end else begin
            seg_len = remain_ff;
         end
      end
   end

   always_comb begin
      state_in          = state_ff;
      page_size_in      = csr_wr_en ? csr_wr_data : page_size_ff;
      ps_in             = ps_ff;
      len_in            = len_ff;
      page_in           = page_ff;
      off_in            = off_ff;
      remain_in         = remain_ff;
      first_in          = first_ff;
      rsp_valid_in      = rsp_valid_ff & ~rsp_tready;
      rsp_data_in       = rsp_data_ff;
      rsp_last_in       = rsp_last_ff;
      div_ctrl.start    = 1'b0;
      div_ctrl.dividend = addr_sel;
      div_ctrl.divisor  = ps_clamped;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               div_ctrl.start = 1'b1;
               ps_in          = ps_clamped;
               len_in         = req_tdata[REQ_TDATA_W-1:ADDR_W];
               state_in       = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               page_in  = div_stat.quotient[PAGE_W-1:0];
               off_in   = div_stat.remainder;
               first_in = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{RSP_PAD_W{1'b0}}, seg_len, off_ff[OFF_W-1:0], page_ff};
               rsp_last_in  = seg_last;
               page_in      = page_ff + 1'b1;
               off_in       = '0;
               first_in     = 1'b0;
               remain_in    = rem_next;
               if (seg_last)
                  state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         page_size_ff <= PAGE_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         page_size_ff <= page_size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ps_ff       <= ps_in;
      len_ff      <= len_in;
      page_ff     <= page_in;
      off_ff      <= off_in;
      remain_ff   <= remain_in;
      first_ff    <= first_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> sv/pbas_checker.sv
// ----------------------------------------------------------------------------
// Page boundary access split - port checker
// Port-level checks on the request and segment channels, bound to the top.
// ----------------------------------------------------------------------------
`include "page_boundary_access_split_assert.svh"

module pbas_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [pbas_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic                              rsp_tlast
);
   import pbas_pkg::*;

   // a segment that is not the last one never carries zero bytes
   `PBAS_ASSERT_IMPL(a_mid_seg_nonzero, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tdata[PAGE_W+OFF_W+LEN_W-1:PAGE_W+OFF_W] != '0, "non-final segment of zero length")

   // once an item is taken the divider runs, so no second item next cycle
   `PBAS_ASSERT_NEXT(a_busy_after_take, clock, reset, req_tvalid && req_tready, !req_tready, "request taken again while dividing")

   // a waiting segment is not withdrawn
   `PBAS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "segment dropped while stalled")

endmodule

bind page_boundary_access_split pbas_checker u_pbas_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
